>>> design/u8lc_pkg.sv
// shared types and constants for the utf8 lowercase stream
`default_nettype none
package u8lc_pkg;
  typedef logic [7:0] byte_t;
  localparam byte_t CaseOffset = 8'h20;
endpackage
`default_nettype wire

>>> design/u8lc_if.sv
// valid/ready channel interfaces for input and result items
`default_nettype none
interface u8lc_in_if;
  logic valid;
  logic ready;
  logic [7:0] in_byte;
  logic stream_end;
  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface u8lc_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic run_last;
  logic text_last;
  modport source (output valid, output out_byte, output run_last, output text_last,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input text_last,
                output ready);
endinterface
`default_nettype wire

>>> design/utf8_lowercase_stream.sv
// utf8 lowercase stream: folds capitals in a utf8 byte stream to lower case
// usage:
//   in_ch  : one utf8 byte per item, stream_end on the final byte of a text
//   out_ch : one output byte per item; run_last marks the last byte caused by
//            an input byte, text_last marks the final byte of the text
//   bytes of a two or three byte group are held until the group completes,
//   then the mapped group (one to three bytes) is loaded into a result buffer
//   one input byte is taken per cycle while the result buffer is empty or
//   drains its last byte on that same cycle; a group that yields n bytes
//   holds the input until its last result byte drains, so single byte results
//   run at one byte per cycle while the receiver is ready
//   first result byte is registered, out in the cycle after the completing byte
//   reset clears the gathering state and the result buffer
//   when the receiver stalls the result buffer holds and the input stalls
`default_nettype none
module utf8_lowercase_stream (
  input  wire logic clk,
  input  wire logic rst_n,
  u8lc_in_if.sink    in_ch,
  u8lc_out_if.source out_ch
);
  typedef logic [7:0] b8_t;

  b8_t        held0_r, held1_r;
  logic [1:0] hcnt_r, glen_r, pass_r;
  b8_t        ob_r [3];
  logic [1:0] on_r, oidx_r;
  logic       oend_r;

  b8_t        buf_c [3];
  logic [1:0] n_c;
  b8_t        mp_o [3];
  logic [1:0] mp_n;
  b8_t        mt_o [3];
  logic [1:0] mt_n;
  logic [1:0] hcnt_nxt, glen_nxt, pass_nxt;
  b8_t        held0_nxt, held1_nxt;
  logic       busy, last_out, acc;
  b8_t        b;
  logic       e;

  assign b = in_ch.in_byte;
  assign e = in_ch.stream_end;
  assign busy = on_r != 2'd0;
  assign last_out = oidx_r == on_r - 2'd1;
  assign in_ch.ready = !busy || (out_ch.ready && last_out);
  assign acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = busy;
  assign out_ch.out_byte = ob_r[oidx_r];
  assign out_ch.run_last = last_out;
  assign out_ch.text_last = last_out && oend_r;

  // two byte group map
  always_comb begin
    b8_t c0, c1;
    logic hit;
    c0 = held0_r;
    c1 = b;
    hit = 1'b1;
    mp_n = 2'd2;
    mp_o[0] = c0;
    mp_o[1] = c1;
    mp_o[2] = 8'h00;
    unique case ({c0, c1})
      16'hc4b0: begin mp_n = 2'd1; mp_o[0] = 8'h69; mp_o[1] = 8'h00; end
      16'hd280: begin mp_o[0] = 8'hd2; mp_o[1] = 8'h81; end
      16'hc4bf: begin mp_o[0] = 8'hc5; mp_o[1] = 8'h80; end
      16'hc5b8: begin mp_o[0] = 8'hc3; mp_o[1] = 8'hbf; end
      16'hc681: begin mp_o[0] = 8'hc9; mp_o[1] = 8'h93; end
      16'hc686: begin mp_o[0] = 8'hc9; mp_o[1] = 8'h94; end
      16'hc689: begin mp_o[0] = 8'hc9; mp_o[1] = 8'h96; end
      16'hc68a: begin mp_o[0] = 8'hc9; mp_o[1] = 8'h97; end
      16'hc68e: begin mp_o[0] = 8'hc7; mp_o[1] = 8'h9d; end
      16'hc68f: begin mp_o[0] = 8'hc9; mp_o[1] = 8'h99; end
      16'hc690: begin mp_o[0] = 8'hc9; mp_o[1] = 8'h9b; end
      16'hc693: begin mp_o[0] = 8'hc9; mp_o[1] = 8'ha0; end
      16'hc694: begin mp_o[0] = 8'hc9; mp_o[1] = 8'ha3; end
      16'hc696: begin mp_o[0] = 8'hc9; mp_o[1] = 8'ha9; end
      16'hc697: begin mp_o[0] = 8'hc9; mp_o[1] = 8'ha8; end
      16'hc69c: begin mp_o[0] = 8'hc9; mp_o[1] = 8'haf; end
      16'hc69d: begin mp_o[0] = 8'hc9; mp_o[1] = 8'hb2; end
      16'hc69f: begin mp_o[0] = 8'hc9; mp_o[1] = 8'hb5; end
      16'hc784: begin mp_o[0] = 8'hc7; mp_o[1] = 8'h86; end
      16'hc787: begin mp_o[0] = 8'hc7; mp_o[1] = 8'h89; end
      16'hc78a: begin mp_o[0] = 8'hc7; mp_o[1] = 8'h8c; end
      16'hc7b1: begin mp_o[0] = 8'hc7; mp_o[1] = 8'hb3; end
      16'hc7b6: begin mp_o[0] = 8'hc6; mp_o[1] = 8'h95; end
      16'hc7b7: begin mp_o[0] = 8'hc6; mp_o[1] = 8'hbf; end
      16'hc8a0: begin mp_o[0] = 8'hc6; mp_o[1] = 8'h9e; end
      16'hc6a6: begin mp_o[0] = 8'hca; mp_o[1] = 8'h80; end
      16'hc6a9: begin mp_o[0] = 8'hca; mp_o[1] = 8'h83; end
      16'hc6ae: begin mp_o[0] = 8'hca; mp_o[1] = 8'h88; end
      16'hc6b1: begin mp_o[0] = 8'hca; mp_o[1] = 8'h8a; end
      16'hc6b2: begin mp_o[0] = 8'hca; mp_o[1] = 8'h8b; end
      16'hc6b7: begin mp_o[0] = 8'hca; mp_o[1] = 8'h92; end
      16'hce86: begin mp_o[0] = 8'hce; mp_o[1] = 8'hac; end
      16'hce88: begin mp_o[0] = 8'hce; mp_o[1] = 8'had; end
      16'hce89: begin mp_o[0] = 8'hce; mp_o[1] = 8'hae; end
      16'hce8a: begin mp_o[0] = 8'hce; mp_o[1] = 8'haf; end
      16'hce8c: begin mp_o[0] = 8'hcf; mp_o[1] = 8'h8c; end
      16'hce8e: begin mp_o[0] = 8'hcf; mp_o[1] = 8'h8d; end
      16'hce8f: begin mp_o[0] = 8'hcf; mp_o[1] = 8'h8e; end
      16'hcfb4: begin mp_o[0] = 8'hce; mp_o[1] = 8'hb8; end
      16'hc7ba, 16'hc7bc, 16'hc7be, 16'hc78d, 16'hc78f, 16'hc7b4, 16'hc7b8,
      16'hc682, 16'hc684, 16'hc687, 16'hc68b, 16'hc691, 16'hc698, 16'hc6a0,
      16'hc6a2, 16'hc6a4, 16'hc6a7, 16'hc6ac, 16'hc6af, 16'hc6b3, 16'hc6b5,
      16'hc6b8, 16'hc6bc: mp_o[1] = c1 + 8'd1;
      default: hit = 1'b0;
    endcase
    if (!hit) begin
      priority if (c0 == 8'hce && c1 >= 8'h91 && c1 <= 8'h9f) mp_o[1] = c1 + 8'h20;
      else if (c0 == 8'hd0 && c1 >= 8'h90 && c1 <= 8'h9f) mp_o[1] = c1 + 8'h20;
      else if (c0 == 8'hd5 && c1 >= 8'h80 && c1 <= 8'h8f) mp_o[1] = c1 + 8'h30;
      else if (c0 == 8'hd0 && c1 >= 8'ha0 && c1 <= 8'haf) begin
        mp_o[0] = c0 + 8'd1; mp_o[1] = c1 + 8'he0;
      end else if (c0 == 8'hd0 && c1 >= 8'h80 && c1 <= 8'h8f) begin
        mp_o[0] = c0 + 8'd1; mp_o[1] = c1 + 8'h10;
      end else if (c0 == 8'hd4 && c1 >= 8'hb1 && c1 <= 8'hbf) begin
        mp_o[0] = c0 + 8'd1; mp_o[1] = c1 + 8'hf0;
      end else if (c0 == 8'hd5 && c1 >= 8'h90 && c1 <= 8'h96) begin
        mp_o[0] = c0 + 8'd1; mp_o[1] = c1 + 8'hf0;
      end else if (!c1[0] && ((c0 == 8'hc4 && c1 >= 8'h80 && c1 <= 8'hae)
          || (c0 == 8'hc4 && c1 >= 8'hb2 && c1 <= 8'hb6)
          || (c0 == 8'hc5 && c1 >= 8'h8a && c1 <= 8'h8e)
          || (c0 == 8'hc5 && c1 >= 8'h90 && c1 <= 8'hae)
          || (c0 == 8'hc5 && c1 >= 8'hb0 && c1 <= 8'hb6)
          || (c0 == 8'hc7 && c1 >= 8'h9e && c1 <= 8'hae)
          || (c0 == 8'hc8 && c1 >= 8'hb0 && c1 <= 8'hb2)
          || (c0 == 8'hcf && c1 >= 8'h98 && c1 <= 8'hae)
          || (c0 == 8'hd1 && c1 >= 8'ha0 && c1 <= 8'hbe)
          || (c0 == 8'hd2 && c1 >= 8'h8a && c1 <= 8'hbe)
          || (c0 == 8'hd4 && c1 >= 8'h80 && c1 <= 8'h8e)))
        mp_o[1] = c1 + 8'd1;
      else if (c1[0] && ((c0 == 8'hc4 && c1 >= 8'hb9 && c1 <= 8'hbd)
          || (c0 == 8'hc5 && c1 >= 8'h81 && c1 <= 8'h87)
          || (c0 == 8'hc5 && c1 >= 8'hb9 && c1 <= 8'hbd)
          || (c0 == 8'hc7 && c1 >= 8'h91 && c1 <= 8'h9b)
          || (c0 == 8'hd3 && c1 >= 8'h81 && c1 <= 8'h8d)))
        mp_o[1] = c1 + 8'd1;
      else if (c0 == 8'hc3 && c1 >= 8'h80 && c1 <= 8'h9e && c1 != 8'h97)
        mp_o[1] = c1 + u8lc_pkg::CaseOffset;
      else if (c0 == 8'hce && c1 >= 8'ha0 && c1 <= 8'hab && c1 != 8'ha2) begin
        mp_o[0] = c0 + 8'd1; mp_o[1] = c1 + 8'he0;
      end else if (!c1[0] && ((c0 == 8'hc8 && c1 >= 8'h80 && c1 <= 8'hae
          && c1 != 8'ha0) || (c0 == 8'hd3 && c1 >= 8'h90 && c1 <= 8'hb8
          && c1 != 8'hb6)))
        mp_o[1] = c1 + 8'd1;
      else mp_o[1] = c1;
    end
  end

  // three byte group map
  always_comb begin
    b8_t c0, c1, c2;
    c0 = held0_r;
    c1 = held1_r;
    c2 = b;
    mt_n = 2'd3;
    mt_o[0] = c0;
    mt_o[1] = c1;
    mt_o[2] = c2;
    if (c0 == 8'he2 && c1 == 8'h84 && c2 == 8'ha6) begin
      mt_n = 2'd2; mt_o[0] = 8'hcf; mt_o[1] = 8'h89;
    end else if (c0 == 8'he2 && c1 == 8'h84 && c2 == 8'hab) begin
      mt_n = 2'd2; mt_o[0] = 8'hc3; mt_o[1] = 8'ha5;
    end else if (c0 == 8'he2 && c1 == 8'h84 && c2 == 8'haa) begin
      mt_n = 2'd1; mt_o[0] = 8'h6b;
    end else if (c0 == 8'he1) begin
      unique case ({c1, c2})
        16'hbeba: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hb0; end
        16'hbebb: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hb1; end
        16'hbf88: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hb2; end
        16'hbf89: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hb3; end
        16'hbf8a: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hb4; end
        16'hbf8b: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hb5; end
        16'hbf98: begin mt_o[1] = 8'hbf; mt_o[2] = 8'h90; end
        16'hbf99: begin mt_o[1] = 8'hbf; mt_o[2] = 8'h91; end
        16'hbf9a: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hb6; end
        16'hbf9b: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hb7; end
        16'hbfa8: begin mt_o[1] = 8'hbf; mt_o[2] = 8'ha0; end
        16'hbfa9: begin mt_o[1] = 8'hbf; mt_o[2] = 8'ha1; end
        16'hbfaa: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hba; end
        16'hbfab: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hbb; end
        16'hbfac: begin mt_o[1] = 8'hbf; mt_o[2] = 8'ha5; end
        16'hbfb8: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hb8; end
        16'hbfb9: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hb9; end
        16'hbfba: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hbc; end
        16'hbfbb: begin mt_o[1] = 8'hbd; mt_o[2] = 8'hbd; end
        default: begin
          priority if ((c1 == 8'hbc && c2 >= 8'h88 && c2 <= 8'h8f)
              || (c1 == 8'hbc && c2 >= 8'h98 && c2 <= 8'h9d)
              || (c1 == 8'hbc && c2 >= 8'ha8 && c2 <= 8'haf)
              || (c1 == 8'hbc && c2 >= 8'hb8 && c2 <= 8'hbf)
              || (c1 == 8'hbd && c2 >= 8'h88 && c2 <= 8'h8d)
              || (c1 == 8'hbd && c2 >= 8'ha8 && c2 <= 8'haf)
              || (c1 == 8'hbe && c2 >= 8'hb8 && c2 <= 8'hb9))
            mt_o[2] = c2 + 8'hf8;
          else if (!c2[0] && ((c1 == 8'hb8 && c2 >= 8'h80 && c2 <= 8'hbe)
              || (c1 == 8'hb9 && c2 >= 8'h80 && c2 <= 8'hbe)
              || (c1 == 8'hba && c2 >= 8'h80 && c2 <= 8'h94)
              || (c1 == 8'hba && c2 >= 8'ha0 && c2 <= 8'hbe)
              || (c1 == 8'hbb && c2 >= 8'h80 && c2 <= 8'hb8)))
            mt_o[2] = c2 + 8'd1;
          else if (c2[0] && c1 == 8'hbd && c2 >= 8'h99 && c2 <= 8'h9f)
            mt_o[2] = c2 + 8'hf8;
          else mt_o[2] = c2;
        end
      endcase
    end
  end

  // step logic
  always_comb begin
    buf_c[0] = 8'h00;
    buf_c[1] = 8'h00;
    buf_c[2] = 8'h00;
    n_c = 2'd0;
    hcnt_nxt = hcnt_r;
    glen_nxt = glen_r;
    pass_nxt = pass_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    if (hcnt_r != 2'd0) begin
      if ({1'b0, hcnt_r} + 3'd1 >= {1'b0, glen_r}) begin
        if (glen_r == 2'd3) begin
          buf_c = mt_o; n_c = mt_n;
        end else begin
          buf_c = mp_o; n_c = mp_n;
        end
        hcnt_nxt = 2'd0;
        glen_nxt = 2'd0;
      end else begin
        if (hcnt_r[0]) held1_nxt = b;
        else held0_nxt = b;
        hcnt_nxt = hcnt_r + 2'd1;
      end
    end else if (pass_r != 2'd0) begin
      buf_c[0] = b; n_c = 2'd1; pass_nxt = pass_r - 2'd1;
    end else if (!b[7]) begin
      buf_c[0] = (b >= 8'h41 && b <= 8'h5a) ? b + u8lc_pkg::CaseOffset : b;
      n_c = 2'd1;
    end else if (b[7:5] == 3'b110) begin
      held0_nxt = b; hcnt_nxt = 2'd1; glen_nxt = 2'd2;
    end else if (b[7:4] == 4'he) begin
      held0_nxt = b; hcnt_nxt = 2'd1; glen_nxt = 2'd3;
    end else if (b[7:3] == 5'b11110) begin
      buf_c[0] = b; n_c = 2'd1; pass_nxt = 2'd3;
    end else begin
      buf_c[0] = b; n_c = 2'd1;
    end
    if (e) begin
      // flush any partial group; held bytes then current byte
      if (hcnt_nxt != 2'd0) begin
        buf_c[0] = held0_nxt;
        buf_c[1] = held1_nxt;
        n_c = hcnt_nxt;
        if (hcnt_r != 2'd0 && hcnt_nxt != 2'd0) begin
          // current byte was appended, occupies held slot already
        end
      end
      hcnt_nxt = 2'd0;
      glen_nxt = 2'd0;
      pass_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= 2'd0;
      glen_r <= 2'd0;
      pass_r <= 2'd0;
      held0_r <= 8'h00;
      held1_r <= 8'h00;
      on_r <= 2'd0;
      oidx_r <= 2'd0;
      oend_r <= 1'b0;
    end else begin
      if (acc) begin
        hcnt_r <= hcnt_nxt;
        glen_r <= glen_nxt;
        pass_r <= pass_nxt;
        held0_r <= held0_nxt;
        held1_r <= held1_nxt;
        on_r <= n_c;
        oidx_r <= 2'd0;
        oend_r <= e;
        ob_r <= buf_c;
      end else if (busy && out_ch.ready) begin
        if (last_out) on_r <= 2'd0;
        else oidx_r <= oidx_r + 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

>>> tb/tb_utf8_lowercase_stream.sv
// self-checking testbench for the utf8 lowercase stream
`timescale 1ns / 100ps
`default_nettype none
module tb_utf8_lowercase_stream;
  typedef u8lc_pkg::byte_t byte_t;

  localparam int MaxMismatchShown = 10;
  localparam int StallLimit = 2000;
  localparam int HoldOffCycles = 60;

  typedef struct packed {
    byte_t out_byte;
    logic  run_last;
    logic  text_last;
  } fold_result_t;

  class fold_scoreboard;
    fold_result_t pending_bytes[$];
    int           mismatches;
    int           orphans;
    byte_t        held[2];
    logic [1:0]   held_cnt;
    logic [1:0]   group_len;
    logic [1:0]   pass_left;

    function void clear();
      held[0] = '0;
      held[1] = '0;
      held_cnt = '0;
      group_len = '0;
      pass_left = '0;
    endfunction

    static function bit par_ok(byte_t v, int par);
      return par == 2 || int'(v[0]) == par;
    endfunction

    static function int fold_pair(byte_t c0, byte_t c1, ref byte_t o[3]);
      logic [15:0] k;
      k = {c0, c1};
      o[0] = c0;
      o[1] = c1;
      case (k)
        16'hc4b0: begin o[0] = 8'h69; return 1; end
        16'hd280: begin o[0] = 8'hd2; o[1] = 8'h81; return 2; end
        16'hc4bf: begin o[0] = 8'hc5; o[1] = 8'h80; return 2; end
        16'hc5b8: begin o[0] = 8'hc3; o[1] = 8'hbf; return 2; end
        16'hc681: begin o[0] = 8'hc9; o[1] = 8'h93; return 2; end
        16'hc686: begin o[0] = 8'hc9; o[1] = 8'h94; return 2; end
        16'hc689: begin o[0] = 8'hc9; o[1] = 8'h96; return 2; end
        16'hc68a: begin o[0] = 8'hc9; o[1] = 8'h97; return 2; end
        16'hc68e: begin o[0] = 8'hc7; o[1] = 8'h9d; return 2; end
        16'hc68f: begin o[0] = 8'hc9; o[1] = 8'h99; return 2; end
        16'hc690: begin o[0] = 8'hc9; o[1] = 8'h9b; return 2; end
        16'hc693: begin o[0] = 8'hc9; o[1] = 8'ha0; return 2; end
        16'hc694: begin o[0] = 8'hc9; o[1] = 8'ha3; return 2; end
        16'hc696: begin o[0] = 8'hc9; o[1] = 8'ha9; return 2; end
        16'hc697: begin o[0] = 8'hc9; o[1] = 8'ha8; return 2; end
        16'hc69c: begin o[0] = 8'hc9; o[1] = 8'haf; return 2; end
        16'hc69d: begin o[0] = 8'hc9; o[1] = 8'hb2; return 2; end
        16'hc69f: begin o[0] = 8'hc9; o[1] = 8'hb5; return 2; end
        16'hc784: begin o[0] = 8'hc7; o[1] = 8'h86; return 2; end
        16'hc787: begin o[0] = 8'hc7; o[1] = 8'h89; return 2; end
        16'hc78a: begin o[0] = 8'hc7; o[1] = 8'h8c; return 2; end
        16'hc7b1: begin o[0] = 8'hc7; o[1] = 8'hb3; return 2; end
        16'hc7b6: begin o[0] = 8'hc6; o[1] = 8'h95; return 2; end
        16'hc7b7: begin o[0] = 8'hc6; o[1] = 8'hbf; return 2; end
        16'hc8a0: begin o[0] = 8'hc6; o[1] = 8'h9e; return 2; end
        16'hc6a6: begin o[0] = 8'hca; o[1] = 8'h80; return 2; end
        16'hc6a9: begin o[0] = 8'hca; o[1] = 8'h83; return 2; end
        16'hc6ae: begin o[0] = 8'hca; o[1] = 8'h88; return 2; end
        16'hc6b1: begin o[0] = 8'hca; o[1] = 8'h8a; return 2; end
        16'hc6b2: begin o[0] = 8'hca; o[1] = 8'h8b; return 2; end
        16'hc6b7: begin o[0] = 8'hca; o[1] = 8'h92; return 2; end
        16'hce86: begin o[0] = 8'hce; o[1] = 8'hac; return 2; end
        16'hce88: begin o[0] = 8'hce; o[1] = 8'had; return 2; end
        16'hce89: begin o[0] = 8'hce; o[1] = 8'hae; return 2; end
        16'hce8a: begin o[0] = 8'hce; o[1] = 8'haf; return 2; end
        16'hce8c: begin o[0] = 8'hcf; o[1] = 8'h8c; return 2; end
        16'hce8e: begin o[0] = 8'hcf; o[1] = 8'h8d; return 2; end
        16'hce8f: begin o[0] = 8'hcf; o[1] = 8'h8e; return 2; end
        16'hcfb4: begin o[0] = 8'hce; o[1] = 8'hb8; return 2; end
        16'hc7ba, 16'hc7bc, 16'hc7be, 16'hc78d, 16'hc78f, 16'hc7b4, 16'hc7b8,
        16'hc682, 16'hc684, 16'hc687, 16'hc68b, 16'hc691, 16'hc698, 16'hc6a0,
        16'hc6a2, 16'hc6a4, 16'hc6a7, 16'hc6ac, 16'hc6af, 16'hc6b3, 16'hc6b5,
        16'hc6b8, 16'hc6bc: begin
          o[1] = c1 + 8'd1;
          return 2;
        end
        default: ;
      endcase
      begin
        // c0, lo, hi, parity, skip, lead add, delta
        logic [7:0] rng[27][7];
        rng = '{
          '{8'hce, 8'h91, 8'h9f, 2, 0, 0, 8'h20}, '{8'hd0, 8'h90, 8'h9f, 2, 0, 0, 8'h20},
          '{8'hd5, 8'h80, 8'h8f, 2, 0, 0, 8'h30}, '{8'hd0, 8'ha0, 8'haf, 2, 0, 1, 8'he0},
          '{8'hd0, 8'h80, 8'h8f, 2, 0, 1, 8'h10}, '{8'hd4, 8'hb1, 8'hbf, 2, 0, 1, 8'hf0},
          '{8'hd5, 8'h90, 8'h96, 2, 0, 1, 8'hf0},
          '{8'hc4, 8'h80, 8'hae, 0, 0, 0, 1}, '{8'hc4, 8'hb2, 8'hb6, 0, 0, 0, 1},
          '{8'hc4, 8'hb9, 8'hbd, 1, 0, 0, 1}, '{8'hc5, 8'h81, 8'h87, 1, 0, 0, 1},
          '{8'hc5, 8'h8a, 8'h8e, 0, 0, 0, 1}, '{8'hc5, 8'h90, 8'hae, 0, 0, 0, 1},
          '{8'hc5, 8'hb0, 8'hb6, 0, 0, 0, 1}, '{8'hc5, 8'hb9, 8'hbd, 1, 0, 0, 1},
          '{8'hc7, 8'h91, 8'h9b, 1, 0, 0, 1}, '{8'hc7, 8'h9e, 8'hae, 0, 0, 0, 1},
          '{8'hc8, 8'hb0, 8'hb2, 0, 0, 0, 1}, '{8'hcf, 8'h98, 8'hae, 0, 0, 0, 1},
          '{8'hd1, 8'ha0, 8'hbe, 0, 0, 0, 1}, '{8'hd2, 8'h8a, 8'hbe, 0, 0, 0, 1},
          '{8'hd3, 8'h81, 8'h8d, 1, 0, 0, 1}, '{8'hd4, 8'h80, 8'h8e, 0, 0, 0, 1},
          '{8'hc3, 8'h80, 8'h9e, 2, 8'h97, 0, 8'h20},
          '{8'hce, 8'ha0, 8'hab, 2, 8'ha2, 1, 8'he0},
          '{8'hc8, 8'h80, 8'hae, 0, 8'ha0, 0, 1}, '{8'hd3, 8'h90, 8'hb8, 0, 8'hb6, 0, 1}};
        foreach (rng[i]) begin
          if (rng[i][0] == c0 && c1 >= rng[i][1] && c1 <= rng[i][2]
              && par_ok(c1, rng[i][3]) && (rng[i][4] == 0 || c1 != rng[i][4])) begin
            o[0] = c0 + rng[i][5];
            o[1] = c1 + rng[i][6];
            return 2;
          end
        end
      end
      return 2;
    endfunction

    static function int fold_triple(byte_t c0, byte_t c1, byte_t c2, ref byte_t o[3]);
      logic [7:0] rng[13][5];
      rng = '{
        '{8'hbc, 8'h88, 8'h8f, 2, 8'hf8}, '{8'hbc, 8'h98, 8'h9d, 2, 8'hf8},
        '{8'hbc, 8'ha8, 8'haf, 2, 8'hf8}, '{8'hbc, 8'hb8, 8'hbf, 2, 8'hf8},
        '{8'hbd, 8'h88, 8'h8d, 2, 8'hf8}, '{8'hbd, 8'ha8, 8'haf, 2, 8'hf8},
        '{8'hbe, 8'hb8, 8'hb9, 2, 8'hf8}, '{8'hb8, 8'h80, 8'hbe, 0, 1},
        '{8'hb9, 8'h80, 8'hbe, 0, 1}, '{8'hba, 8'h80, 8'h94, 0, 1},
        '{8'hba, 8'ha0, 8'hbe, 0, 1}, '{8'hbb, 8'h80, 8'hb8, 0, 1},
        '{8'hbd, 8'h99, 8'h9f, 1, 8'hf8}};
      o[0] = c0;
      o[1] = c1;
      o[2] = c2;
      if (c0 == 8'he2 && c1 == 8'h84) begin
        if (c2 == 8'ha6) begin o[0] = 8'hcf; o[1] = 8'h89; return 2; end
        if (c2 == 8'hab) begin o[0] = 8'hc3; o[1] = 8'ha5; return 2; end
        if (c2 == 8'haa) begin o[0] = 8'h6b; return 1; end
      end
      if (c0 != 8'he1) return 3;
      o[0] = 8'he1;
      case ({c1, c2})
        16'hbeba: begin o[1] = 8'hbd; o[2] = 8'hb0; return 3; end
        16'hbebb: begin o[1] = 8'hbd; o[2] = 8'hb1; return 3; end
        16'hbf88: begin o[1] = 8'hbd; o[2] = 8'hb2; return 3; end
        16'hbf89: begin o[1] = 8'hbd; o[2] = 8'hb3; return 3; end
        16'hbf8a: begin o[1] = 8'hbd; o[2] = 8'hb4; return 3; end
        16'hbf8b: begin o[1] = 8'hbd; o[2] = 8'hb5; return 3; end
        16'hbf98: begin o[1] = 8'hbf; o[2] = 8'h90; return 3; end
        16'hbf99: begin o[1] = 8'hbf; o[2] = 8'h91; return 3; end
        16'hbf9a: begin o[1] = 8'hbd; o[2] = 8'hb6; return 3; end
        16'hbf9b: begin o[1] = 8'hbd; o[2] = 8'hb7; return 3; end
        16'hbfa8: begin o[1] = 8'hbf; o[2] = 8'ha0; return 3; end
        16'hbfa9: begin o[1] = 8'hbf; o[2] = 8'ha1; return 3; end
        16'hbfaa: begin o[1] = 8'hbd; o[2] = 8'hba; return 3; end
        16'hbfab: begin o[1] = 8'hbd; o[2] = 8'hbb; return 3; end
        16'hbfac: begin o[1] = 8'hbf; o[2] = 8'ha5; return 3; end
        16'hbfb8: begin o[1] = 8'hbd; o[2] = 8'hb8; return 3; end
        16'hbfb9: begin o[1] = 8'hbd; o[2] = 8'hb9; return 3; end
        16'hbfba: begin o[1] = 8'hbd; o[2] = 8'hbc; return 3; end
        16'hbfbb: begin o[1] = 8'hbd; o[2] = 8'hbd; return 3; end
        default: ;
      endcase
      foreach (rng[i]) begin
        if (rng[i][0] == c1 && c2 >= rng[i][1] && c2 <= rng[i][2]
            && par_ok(c2, rng[i][3])) begin
          o[2] = c2 + rng[i][4];
          return 3;
        end
      end
      return 3;
    endfunction

    function void note_input(byte_t b, logic fin);
      byte_t buf_b[3];
      byte_t o[3];
      int n;
      fold_result_t r;
      n = 0;
      if (held_cnt > 0) begin
        if (held_cnt + 2'd1 >= group_len) begin
          if (group_len == 2'd3) n = fold_triple(held[0], held[1], b, o);
          else n = fold_pair(held[0], b, o);
          buf_b = o;
          held_cnt = '0;
          group_len = '0;
        end else begin
          held[held_cnt[0]] = b;
          held_cnt++;
        end
      end else if (pass_left > 0) begin
        buf_b[n++] = b;
        pass_left--;
      end else if (b < 8'h80) begin
        buf_b[n++] = (b >= "A" && b <= "Z") ? b + u8lc_pkg::CaseOffset : b;
      end else if (b >= 8'hc0 && b <= 8'hdf) begin
        held[0] = b; held_cnt = 2'd1; group_len = 2'd2;
      end else if (b >= 8'he0 && b <= 8'hef) begin
        held[0] = b; held_cnt = 2'd1; group_len = 2'd3;
      end else if (b >= 8'hf0 && b <= 8'hf7) begin
        buf_b[n++] = b;
        pass_left = 2'd3;
      end else begin
        buf_b[n++] = b;
      end
      if (fin) begin
        for (int i = 0; i < held_cnt && i < 2; i++) buf_b[n++] = held[i];
        clear();
      end
      for (int k = 0; k < n; k++) begin
        r.out_byte = buf_b[k];
        r.run_last = (k == n - 1);
        r.text_last = (k == n - 1) && fin;
        pending_bytes.insert(pending_bytes.size(), r);
      end
    endfunction

    function void check_result(fold_result_t got);
      fold_result_t want;
      if (pending_bytes.size() == 0) begin
        orphans++;
        if (mismatches + orphans <= MaxMismatchShown)
          $display("unexpected output byte %h rl=%b tl=%b", got.out_byte,
                   got.run_last, got.text_last);
        return;
      end
      want = pending_bytes.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches + orphans <= MaxMismatchShown)
          $display("mismatch: expected %h rl=%b tl=%b, got %h rl=%b tl=%b",
                   want.out_byte, want.run_last, want.text_last,
                   got.out_byte, got.run_last, got.text_last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  u8lc_in_if  in_ch();
  u8lc_out_if out_ch();
  fold_scoreboard sb;
  bit busy_phase;
  bit hold_off;
  int quiet_cycles;

  utf8_lowercase_stream dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function bit idle_now();
    return !busy_phase && $urandom_range(99) < 25;
  endfunction

  task automatic send_byte(byte_t b, logic fin);
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.stream_end <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(b, fin);
  endtask

  task automatic send_text(byte_t t[$]);
    foreach (t[i]) send_byte(t[i], i == t.size() - 1);
  endtask

  function byte_t rand_cont();
    return byte_t'($urandom_range(8'hbf, 8'h80));
  endfunction

  task automatic send_random_group();
    byte_t leads[$] = '{8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hce, 8'hcf,
                        8'hd0, 8'hd1, 8'hd2, 8'hd3, 8'hd4, 8'hd5};
    int pick;
    logic fin;
    pick = $urandom_range(9);
    fin = ($urandom_range(11) == 0);
    case (pick)
      0, 1: send_byte(byte_t'($urandom_range(8'h7f)), fin);
      2: send_byte(byte_t'($urandom_range(8'h5a, 8'h41)), fin);
      3, 4: begin
        send_byte(leads[$urandom_range(leads.size() - 1)], 1'b0);
        send_byte(rand_cont(), fin);
      end
      5: begin
        send_byte(8'he1, 1'b0);
        send_byte(byte_t'($urandom_range(8'hbf, 8'hb8)), 1'b0);
        send_byte(rand_cont(), fin);
      end
      6: begin
        send_byte(8'he2, 1'b0);
        send_byte(8'h84, 1'b0);
        send_byte(byte_t'($urandom_range(8'hab, 8'ha5)), fin);
      end
      7: begin
        send_byte(byte_t'($urandom_range(8'hf7, 8'hf0)), 1'b0);
        repeat (3) send_byte(byte_t'($urandom), 1'b0);
      end
      default: send_byte(byte_t'($urandom), fin);
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.out_byte, out_ch.run_last, out_ch.text_last});
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off = 1'b0;
      end
      out_ch.ready <= busy_phase || $urandom_range(99) >= 25;
      @(posedge clk);
    end
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < StallLimit) @(posedge clk);
    $display("utf8_lowercase_stream regression: fail");
    $finish;
  end

  initial begin
    byte_t extra;
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.stream_end = 1'b0;
    busy_phase = 1'b0;
    hold_off = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ascii edges, mapped groups, passthrough, truncation flush
    send_text('{8'h00, "A", "Z", "@", "[", 8'h7f, 8'hc4, 8'hb0, 8'hc3, 8'h97});
    send_text('{8'he2, 8'h84, 8'haa, 8'he1, 8'hbf, 8'hbb, 8'hf7, 8'hff, 8'h80,
                8'h41, 8'hff, 8'h80});
    send_text('{8'he1, 8'hb8});
    send_text('{8'hf0, 8'h41});
    send_text('{8'hdf});

    // receiver holds off while the sender keeps going
    hold_off = 1'b1;
    busy_phase = 1'b1;
    repeat (20) send_random_group();
    busy_phase = 1'b0;

    while (sb.held_cnt != 0 || sb.pass_left != 0 || $urandom_range(60) > 0)
      send_random_group();
    extra = byte_t'($urandom);
    send_byte(extra, 1'b1);
    in_ch.valid <= 1'b0;

    while (sb.pending_bytes.size() != 0 && quiet_cycles < StallLimit) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending_bytes.size() == 0)
      $display("utf8_lowercase_stream regression: pass");
    else
      $display("utf8_lowercase_stream regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
